>>> rtl/core/ebgd_pkg.sv
// ----------------------------------------------------------------------------
// ebgd_pkg
// Shared types and constants for the energy burst gesture detector: register
// map, reset values, phase codes and the control bundles between modules.
// ----------------------------------------------------------------------------
package ebgd_pkg;

   localparam int SAMPLE_BITS_DEF = 16;

   // configuration port
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_SMOOTHING_COEFF  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_RATIO    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_FLOOR    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EXIT_RATIO       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCAN_LENGTH      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_EARLY_EXIT_COUNT = 3'd5;

   localparam int COEFF_W = 16;
   localparam int RATIO_W = 12;
   localparam int COUNT_W = 16;

   localparam logic [COEFF_W-1:0] RST_SMOOTHING_COEFF  = 16'd64225;
   localparam logic [RATIO_W-1:0] RST_TRIGGER_RATIO    = 12'd512;
   localparam logic [CSR_W-1:0]   RST_TRIGGER_FLOOR    = 16'd328;
   localparam logic [RATIO_W-1:0] RST_EXIT_RATIO       = 12'd128;
   localparam logic [COUNT_W-1:0] RST_SCAN_LENGTH      = 16'd24000;
   localparam logic [COUNT_W-1:0] RST_EARLY_EXIT_COUNT = 16'd12000;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // multiplier operand B carries 65536 - coeff, so one bit wider than coeff
   localparam int MUL_B_W = COEFF_W + 1;
   localparam logic [MUL_B_W-1:0] COEFF_ONE = {1'b1, {COEFF_W{1'b0}}};

   // phase codes
   localparam int PHASE_W = 2;
   localparam logic [PHASE_W-1:0] MODE_IDLE = 2'd0;
   localparam logic [PHASE_W-1:0] MODE_SCAN = 2'd1;
   localparam logic [PHASE_W-1:0] MODE_LOCK = 2'd2;

   typedef struct packed {
      logic [COEFF_W-1:0] smoothing_coeff;
      logic [RATIO_W-1:0] trigger_ratio;
      logic [CSR_W-1:0]   trigger_floor;
      logic [RATIO_W-1:0] exit_ratio;
      logic [COUNT_W-1:0] scan_length;
      logic [COUNT_W-1:0] early_exit_count;
   } cfg_type;

   typedef struct packed {
      logic mul_en;     // register a new product
      logic acc_init;   // load rounding constant into accumulator
      logic acc_add;    // add product into accumulator
      logic acc_shift;  // product enters the sum shifted left by 8
   } mac_ctrl_type;

endpackage

>>> rtl/core/ebgd_req_if.sv
// ----------------------------------------------------------------------------
// ebgd_req_if
// Input channel: one stereo sample pair per beat.
// ----------------------------------------------------------------------------
interface ebgd_req_if #(
   parameter int SAMPLE_BITS = ebgd_pkg::SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_left;
   logic signed [SAMPLE_BITS-1:0] sample_right;

   modport source (output valid, output sample_left, output sample_right, input ready);
   modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

>>> rtl/core/ebgd_rsp_if.sv
// ----------------------------------------------------------------------------
// ebgd_rsp_if
// Result channel: phase, captured level and smoothed level per beat.
// ----------------------------------------------------------------------------
interface ebgd_rsp_if #(
   parameter int SAMPLE_BITS = ebgd_pkg::SAMPLE_BITS_DEF
) ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               phase;
   logic [SAMPLE_BITS-1:0]   captured_level;
   logic [SAMPLE_BITS+6:0]   average_level;

   modport source (output valid, output phase, output captured_level,
                   output average_level, input ready);
   modport sink   (input valid, input phase, input captured_level,
                   input average_level, output ready);
endinterface

>>> rtl/core/ebgd_csr.sv
// ----------------------------------------------------------------------------
// ebgd_csr
// Configuration register file, write only, excess data bits dropped.
// ----------------------------------------------------------------------------
module ebgd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [ebgd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ebgd_pkg::CSR_W-1:0]     csr_write_data,
   output ebgd_pkg::cfg_type              cfg
);
   import ebgd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_SMOOTHING_COEFF:  cfg_in.smoothing_coeff  = csr_write_data[COEFF_W-1:0];
            REG_TRIGGER_RATIO:    cfg_in.trigger_ratio    = csr_write_data[RATIO_W-1:0];
            REG_TRIGGER_FLOOR:    cfg_in.trigger_floor    = csr_write_data;
            REG_EXIT_RATIO:       cfg_in.exit_ratio       = csr_write_data[RATIO_W-1:0];
            REG_SCAN_LENGTH:      cfg_in.scan_length      = csr_write_data[COUNT_W-1:0];
            REG_EARLY_EXIT_COUNT: cfg_in.early_exit_count = csr_write_data[COUNT_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smoothing_coeff  <= RST_SMOOTHING_COEFF;
         cfg_ff.trigger_ratio    <= RST_TRIGGER_RATIO;
         cfg_ff.trigger_floor    <= RST_TRIGGER_FLOOR;
         cfg_ff.exit_ratio       <= RST_EXIT_RATIO;
         cfg_ff.scan_length      <= RST_SCAN_LENGTH;
         cfg_ff.early_exit_count <= RST_EARLY_EXIT_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/ebgd_mac.sv
// ----------------------------------------------------------------------------
// ebgd_mac
// Shared multiplier with registered product and a rounding accumulator.
// Used for both average terms and both ratio products.
// ----------------------------------------------------------------------------
module ebgd_mac #(
   parameter int A_W   = 23,
   parameter int ACC_W = 41
) (
   input  logic                           clock,
   input  ebgd_pkg::mac_ctrl_type         ctrl,
   input  logic [A_W-1:0]                 op_a,
   input  logic [ebgd_pkg::MUL_B_W-1:0]   op_b,
   output logic [A_W+ebgd_pkg::MUL_B_W-1:0] prod,
   output logic [ACC_W-1:0]               acc
);
   import ebgd_pkg::*;

   localparam int PROD_W = A_W + MUL_B_W;
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEFF_W - 1);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  acc_in;
   logic [ACC_W-1:0]  addend;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);
   assign addend  = ctrl.acc_shift ? ACC_W'({prod_ff, 8'b0}) : ACC_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_init) begin
         acc_in = ROUND_HALF;
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + addend;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

>>> rtl/core/energy_burst_gesture_detector.sv
// ----------------------------------------------------------------------------
// energy_burst_gesture_detector
// Tracks the level of a stereo stream and detects an energy burst.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one stereo sample pair per beat; rsp_chan returns one
//   beat per sample: phase (0 idle, 1 scanning, 2 locked), the level captured
//   at lock (zero before) and the updated smoothed level, Q(SAMPLE_BITS-1).8.
//   csr_* writes a register; write only while no sample is in flight.
//   Sequence: a sample accepted in idle runs through the steps MUL_OLD,
//   MUL_NEW, ACC_NEW, AVG, MUL_TRIG, MUL_EXIT and DECIDE, and a new sample
//   is accepted only once the sequencer is back in idle. Four products (old
//   average times coefficient, level times its complement, average times
//   both ratios) share a single multiplier under a small sequencer.
//   The result sits in an output register, so the next sample is accepted
//   while a result still waits; if the receiver stalls, the sequencer holds
//   in its last step until the output register frees up.
//   Reset (synchronous, active high) returns the registers to their defaults,
//   phase to idle, and clears average, count and captured level. Lock holds
//   until reset.
// ----------------------------------------------------------------------------
module energy_burst_gesture_detector #(
   parameter int SAMPLE_BITS = ebgd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ebgd_req_if.sink                        req_chan,
   ebgd_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [ebgd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ebgd_pkg::CSR_W-1:0]      csr_write_data
);
   import ebgd_pkg::*;

   localparam int AVG_BITS = SAMPLE_BITS + 7;
   localparam int PROD_W   = AVG_BITS + MUL_B_W;
   localparam int ACC_W    = SAMPLE_BITS + 25;
   localparam int RAW_W    = ACC_W - COEFF_W;
   localparam int CMP_W    = (SAMPLE_BITS > CSR_W) ? SAMPLE_BITS : CSR_W;
   localparam logic [AVG_BITS-1:0] AVG_MAX = {AVG_BITS{1'b1}};

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
   localparam logic [ST_W-1:0] ST_MUL_OLD  = 3'd1;
   localparam logic [ST_W-1:0] ST_MUL_NEW  = 3'd2;
   localparam logic [ST_W-1:0] ST_ACC_NEW  = 3'd3;
   localparam logic [ST_W-1:0] ST_AVG      = 3'd4;
   localparam logic [ST_W-1:0] ST_MUL_TRIG = 3'd5;
   localparam logic [ST_W-1:0] ST_MUL_EXIT = 3'd6;
   localparam logic [ST_W-1:0] ST_DECIDE   = 3'd7;

   cfg_type      cfg;
   mac_ctrl_type mac_ctrl;
   logic [AVG_BITS-1:0]    op_a;
   logic [MUL_B_W-1:0]     op_b;
   logic [PROD_W-1:0]      prod;
   logic [ACC_W-1:0]       acc;

   logic [ST_W-1:0]        state_ff, state_in;
   logic [PHASE_W-1:0]     mode_ff, mode_in;
   logic [AVG_BITS-1:0]    smoothed_ff, smoothed_in;
   logic [COUNT_W-1:0]     scan_count_ff, scan_count_in;
   logic [SAMPLE_BITS-1:0] held_level_ff, held_level_in;
   logic [SAMPLE_BITS-1:0] level_ff, level_in;
   logic                   trig_hit_ff, trig_hit_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0]     rsp_phase_ff, rsp_phase_in;
   logic [SAMPLE_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic [AVG_BITS-1:0]    rsp_avg_ff, rsp_avg_in;

   logic [SAMPLE_BITS-1:0] mag_left, mag_right;
   logic [SAMPLE_BITS:0]   mag_sum;
   logic                   req_fire, out_free;
   logic [PROD_W-1:0]      level_scaled;
   logic [RAW_W-1:0]       avg_raw;
   logic [COUNT_W-1:0]     count_inc;
   logic                   exit_low, lock;

   ebgd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ebgd_mac #(
      .A_W   (AVG_BITS),
      .ACC_W (ACC_W)
   ) u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod),
      .acc   (acc)
   );

   // |x| fits in SAMPLE_BITS unsigned, including the most negative code
   assign mag_left  = req_chan.sample_left[SAMPLE_BITS-1]
                      ? SAMPLE_BITS'(~req_chan.sample_left + 1'b1)
                      : SAMPLE_BITS'(req_chan.sample_left);
   assign mag_right = req_chan.sample_right[SAMPLE_BITS-1]
                      ? SAMPLE_BITS'(~req_chan.sample_right + 1'b1)
                      : SAMPLE_BITS'(req_chan.sample_right);
   assign mag_sum   = {1'b0, mag_left} + {1'b0, mag_right};

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign level_scaled = PROD_W'({level_ff, 16'b0});
   assign avg_raw      = acc[ACC_W-1:COEFF_W];
   assign count_inc    = (scan_count_ff == COUNT_MAX) ? COUNT_MAX
                                                      : scan_count_ff + 1'b1;
   assign exit_low     = level_scaled < prod;

   // operand select and sequencing
   always_comb begin
      op_a     = smoothed_ff;
      op_b     = MUL_B_W'(cfg.smoothing_coeff);
      mac_ctrl = '0;
      state_in = state_ff;
      level_in = level_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               level_in = mag_sum[SAMPLE_BITS:1];
               state_in = ST_MUL_OLD;
            end
         end
         ST_MUL_OLD: begin
            mac_ctrl.mul_en   = 1'b1;
            mac_ctrl.acc_init = 1'b1;
            state_in          = ST_MUL_NEW;
         end
         ST_MUL_NEW: begin
            op_a             = AVG_BITS'(level_ff);
            op_b             = COEFF_ONE - MUL_B_W'(cfg.smoothing_coeff);
            mac_ctrl.mul_en  = 1'b1;
            mac_ctrl.acc_add = 1'b1;
            state_in         = ST_ACC_NEW;
         end
         ST_ACC_NEW: begin
            mac_ctrl.acc_add   = 1'b1;
            mac_ctrl.acc_shift = 1'b1;
            state_in           = ST_AVG;
         end
         ST_AVG: begin
            state_in = ST_MUL_TRIG;
         end
         ST_MUL_TRIG: begin
            op_b            = MUL_B_W'(cfg.trigger_ratio);
            mac_ctrl.mul_en = 1'b1;
            state_in        = ST_MUL_EXIT;
         end
         ST_MUL_EXIT: begin
            op_b            = MUL_B_W'(cfg.exit_ratio);
            mac_ctrl.mul_en = 1'b1;
            state_in        = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // average update, trigger compare, phase decision
   always_comb begin
      smoothed_in   = smoothed_ff;
      trig_hit_in   = trig_hit_ff;
      mode_in       = mode_ff;
      scan_count_in = scan_count_ff;
      held_level_in = held_level_ff;
      lock          = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_phase_in  = rsp_phase_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_avg_in    = rsp_avg_ff;

      if (state_ff == ST_AVG) begin
         if (|avg_raw[RAW_W-1:AVG_BITS]) begin
            smoothed_in = AVG_MAX;
         end else begin
            smoothed_in = avg_raw[AVG_BITS-1:0];
         end
      end

      // product register holds the trigger product during this step
      if (state_ff == ST_MUL_EXIT) begin
         trig_hit_in = (level_scaled > prod) &&
                       (CMP_W'(level_ff) > CMP_W'(cfg.trigger_floor));
      end

      if (state_ff == ST_DECIDE && out_free) begin
         if (mode_ff == MODE_IDLE) begin
            if (trig_hit_ff) begin
               mode_in       = MODE_SCAN;
               scan_count_in = '0;
            end
         end else if (mode_ff == MODE_SCAN) begin
            scan_count_in = count_inc;
            lock = (count_inc >= cfg.scan_length) ||
                   (exit_low && (count_inc > cfg.early_exit_count));
            if (lock) begin
               mode_in       = MODE_LOCK;
               held_level_in = level_ff;
            end
         end
         rsp_valid_in = 1'b1;
         rsp_phase_in = mode_in;
         rsp_level_in = held_level_in;
         rsp_avg_in   = smoothed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_IDLE;
         smoothed_ff   <= '0;
         scan_count_ff <= '0;
         held_level_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         smoothed_ff   <= smoothed_in;
         scan_count_ff <= scan_count_in;
         held_level_ff <= held_level_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff     <= level_in;
      trig_hit_ff  <= trig_hit_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_level_ff <= rsp_level_in;
      rsp_avg_ff   <= rsp_avg_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.phase          = rsp_phase_ff;
   assign rsp_chan.captured_level = rsp_level_ff;
   assign rsp_chan.average_level  = rsp_avg_ff;

   // a result is loaded only by the decision step
   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(state_ff == ST_DECIDE))
      else $error("result raised outside decision step");

   // an accepted sample always starts the sequence
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_MUL_OLD))
      else $error("accepted sample did not start the sequence");

   // lock is sticky until reset
   a_lock_holds: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_LOCK) |=> (mode_ff == MODE_LOCK))
      else $error("locked phase left without reset");

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> (state_ff != ST_IDLE) || rsp_valid_ff)
      else $error("pending result dropped");

endmodule
